FILE: rtl/fca_pkg.sv
// shared types, constants and palette lookup for the fire automaton core
package fca_pkg;

	typedef enum logic [1:0] {
		CMD_RESEED = 2'd0,
		CMD_SPREAD = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	localparam int unsigned HEAT_W = 6;
	localparam logic [HEAT_W-1:0] HEAT_TOP = 6'd36;

	typedef logic [HEAT_W-1:0] heat_t;
	typedef logic [31:0] rgba_t;

	// abgr byte order: red in the low byte, alpha 255, heat 0 transparent
	function automatic rgba_t palette_word(input heat_t heat);
		rgba_t word;
		case (heat)
			6'd0:    word = 32'h00000000;
			6'd1:    word = 32'hFF07071F;
			6'd2:    word = 32'hFF070F2F;
			6'd3:    word = 32'hFF070F47;
			6'd4:    word = 32'hFF071757;
			6'd5:    word = 32'hFF071F67;
			6'd6:    word = 32'hFF071F77;
			6'd7:    word = 32'hFF07278F;
			6'd8:    word = 32'hFF072F9F;
			6'd9:    word = 32'hFF073FAF;
			6'd10:   word = 32'hFF0747BF;
			6'd11:   word = 32'hFF0747C7;
			6'd12:   word = 32'hFF074FDF;
			6'd13:   word = 32'hFF0757DF;
			6'd14:   word = 32'hFF0757DF;
			6'd15:   word = 32'hFF075FD7;
			6'd16:   word = 32'hFF075FD7;
			6'd17:   word = 32'hFF0F67D7;
			6'd18:   word = 32'hFF0F6FCF;
			6'd19:   word = 32'hFF0F77CF;
			6'd20:   word = 32'hFF0F7FCF;
			6'd21:   word = 32'hFF1787CF;
			6'd22:   word = 32'hFF1787C7;
			6'd23:   word = 32'hFF178FC7;
			6'd24:   word = 32'hFF1F97C7;
			6'd25:   word = 32'hFF1F9FBF;
			6'd26:   word = 32'hFF1F9FBF;
			6'd27:   word = 32'hFF27A7BF;
			6'd28:   word = 32'hFF27A7BF;
			6'd29:   word = 32'hFF2FAFBF;
			6'd30:   word = 32'hFF2FAFB7;
			6'd31:   word = 32'hFF2FB7B7;
			6'd32:   word = 32'hFF37B7B7;
			6'd33:   word = 32'hFF6FCFCF;
			6'd34:   word = 32'hFF9FDFDF;
			6'd35:   word = 32'hFFC7EFEF;
			default: word = 32'hFFFFFFFF; // top entry, also any hotter cell
		endcase
		return word;
	endfunction

endpackage

FILE: rtl/fire_cellular_automaton_core.sv
// fire cellular automaton core: heat field memory, column-major spread scan, cell readout
// stages: address, memory read, update/write, palette; the last is the output register
// throughput: one transaction per cycle unless output stall, reseed or sweep holds in_ready
// reset: async active low; afterwards, and after each reseed, the heat memory is swept one
// cell a cycle over the whole field, with in_ready low (cfg writes still taken)
module fire_cellular_automaton_core #(
	parameter int GRID_WIDTH  = 320,
	parameter int GRID_HEIGHT = 168
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel (seed_heat)
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  fca_pkg::heat_t      cfg_data,
	// command channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [1:0]          rand_offset,
	input  logic [8:0]          read_col,
	input  logic [7:0]          read_row,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                wrote,
	output logic [15:0]         write_index,
	output fca_pkg::heat_t      write_value,
	output logic                tick_done,
	output fca_pkg::heat_t      read_heat,
	output fca_pkg::rgba_t      read_color
);
	import fca_pkg::*;

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int TW         = AW + 1;
	localparam int CW         = $clog2(GRID_WIDTH);
	localparam int RW         = $clog2(GRID_HEIGHT);
	localparam int BOT_BASE   = (GRID_HEIGHT - 1) * GRID_WIDTH;

	// heat field memory: one write port, one registered read port
	heat_t heat_mem [CELL_COUNT];

	// global advance: the whole pipe moves unless the output holds an untaken result
	logic adv;
	logic accept;

	// seed register and clearing sweep
	heat_t          seed_heat_q;
	logic           sweep_active_q;
	logic [AW-1:0]  sweep_idx_q;
	heat_t          sweep_seed_q;
	logic           sweep_start;

	// scan position, kept with its linear index so no multiply is needed
	logic [CW-1:0]  scan_col_q;
	logic [RW-1:0]  scan_row_q;
	logic [AW-1:0]  scan_src_q;
	logic           scan_last;
	logic [CW-1:0]  scan_col_nxt;

	// stage 1: command plus cell address
	logic           v_s1;
	cmd_t           cmd_s1;
	logic [1:0]     off_s1;
	logic [AW-1:0]  addr_s1;
	logic           rd_ok_s1;
	logic           done_s1;

	// stage 1 target candidates, both worked out before the heat is known
	logic [TW-1:0]  src_ext;
	logic [TW-1:0]  up_ext;
	logic [TW-1:0]  sub_ext;
	logic [TW-1:0]  t_cold;
	logic [TW-1:0]  t_hot;
	logic           cold_ok;
	logic           hot_ok;

	// stage 2: memory data back, targets chosen, write issued
	logic           v_s2;
	cmd_t           cmd_s2;
	logic           off0_s2;
	logic [AW-1:0]  tcold_s2;
	logic [AW-1:0]  thot_s2;
	logic           cold_ok_s2;
	logic           hot_ok_s2;
	logic           rd_ok_s2;
	logic           done_s2;
	heat_t          rdata_s2;
	logic           fwd_s2;
	heat_t          fwdv_s2;

	heat_t          heat_cur;
	logic           is_spread;
	logic           is_cold;
	logic           pipe_we;
	logic [AW-1:0]  pipe_waddr;
	heat_t          pipe_wval;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	heat_t          mem_wdata;

	// stage 3: result fields less the color
	logic           v_s3;
	logic           wrote_s3;
	logic [AW-1:0]  widx_s3;
	heat_t          wval_s3;
	logic           done_s3;
	heat_t          rheat_s3;

	// stage 4: output register
	logic           v_s4;
	logic           wrote_s4;
	logic [AW-1:0]  widx_s4;
	heat_t          wval_s4;
	logic           done_s4;
	heat_t          rheat_s4;
	rgba_t          color_s4;

	assign adv       = !v_s4 || out_ready;
	assign cfg_ready = 1'b1;

	// no new transaction while a reseed is on its way to the memory or its sweep runs
	assign in_ready = adv && !sweep_active_q
		&& !(v_s1 && cmd_s1 == CMD_RESEED)
		&& !(v_s2 && cmd_s2 == CMD_RESEED);
	assign accept = in_valid && in_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_heat_q <= HEAT_TOP;
		end else if (cfg_valid && cfg_ready) begin
			seed_heat_q <= cfg_data;
		end
	end

	// clearing sweep: zero everywhere, seed heat on the bottom row
	assign sweep_start = adv && v_s2 && cmd_s2 == CMD_RESEED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_active_q <= 1'b1;
			sweep_idx_q    <= '0;
			sweep_seed_q   <= HEAT_TOP;
		end else if (sweep_start) begin
			sweep_active_q <= 1'b1;
			sweep_idx_q    <= '0;
			sweep_seed_q   <= seed_heat_q;
		end else if (sweep_active_q) begin
			if (sweep_idx_q == AW'(CELL_COUNT - 1)) begin
				sweep_active_q <= 1'b0;
			end else begin
				sweep_idx_q <= sweep_idx_q + 1'b1;
			end
		end
	end

	// scan: rows 1..H-1 within a column, then the next column
	assign scan_last    = scan_row_q == RW'(GRID_HEIGHT - 1);
	assign scan_col_nxt = (scan_col_q == CW'(GRID_WIDTH - 1)) ? '0 : scan_col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q <= '0;
			scan_row_q <= RW'(1);
			scan_src_q <= AW'(GRID_WIDTH);
		end else if (accept && cmd_t'(cmd) == CMD_SPREAD) begin
			if (scan_last) begin
				scan_row_q <= RW'(1);
				scan_col_q <= scan_col_nxt;
				scan_src_q <= AW'(GRID_WIDTH) + AW'(scan_col_nxt);
			end else begin
				scan_row_q <= scan_row_q + 1'b1;
				scan_src_q <= scan_src_q + AW'(GRID_WIDTH);
			end
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1 load: spread takes the scan index, read multiplies out row and column
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= cmd_t'(cmd);
			off_s1   <= rand_offset;
			rd_ok_s1 <= (32'(read_col) < GRID_WIDTH) && (32'(read_row) < GRID_HEIGHT);
			done_s1  <= scan_last && scan_col_q == CW'(GRID_WIDTH - 1);
			if (cmd_t'(cmd) == CMD_SPREAD) begin
				addr_s1 <= scan_src_q;
			end else begin
				addr_s1 <= AW'(read_row) * AW'(GRID_WIDTH) + AW'(read_col);
			end
		end
	end

	// cold source: cell straight above; hot source: above, shifted by 1 - offset
	assign src_ext = TW'(addr_s1);
	assign up_ext  = src_ext + 1'b1;
	assign sub_ext = TW'(off_s1) + TW'(GRID_WIDTH);
	assign t_cold  = src_ext - TW'(GRID_WIDTH);
	assign t_hot   = up_ext - sub_ext;
	assign cold_ok = src_ext >= TW'(GRID_WIDTH);
	assign hot_ok  = up_ext >= sub_ext;

	// stage 2 load
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2     <= cmd_s1;
			off0_s2    <= off_s1[0];
			tcold_s2   <= t_cold[AW-1:0];
			thot_s2    <= t_hot[AW-1:0];
			cold_ok_s2 <= cold_ok;
			hot_ok_s2  <= hot_ok;
			rd_ok_s2   <= rd_ok_s1;
			done_s2    <= done_s1;
			// the write leaving stage 2 lands on this same edge, so the read misses it
			fwd_s2     <= pipe_we && pipe_waddr == addr_s1;
			fwdv_s2    <= pipe_wval;
		end
	end

	// stage 2 update
	assign heat_cur   = fwd_s2 ? fwdv_s2 : rdata_s2;
	assign is_spread  = v_s2 && cmd_s2 == CMD_SPREAD;
	assign is_cold    = heat_cur == '0;
	assign pipe_we    = is_spread && (is_cold ? cold_ok_s2 : hot_ok_s2);
	assign pipe_waddr = is_cold ? tcold_s2 : thot_s2;
	assign pipe_wval  = is_cold ? '0 : heat_cur - HEAT_W'(off0_s2);

	// memory ports: the sweep owns the write port while it runs
	assign mem_we    = sweep_active_q || (adv && pipe_we);
	assign mem_waddr = sweep_active_q ? sweep_idx_q : pipe_waddr;
	assign mem_wdata = sweep_active_q
		? ((sweep_idx_q >= AW'(BOT_BASE)) ? sweep_seed_q : '0)
		: pipe_wval;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heat_mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rdata_s2 <= heat_mem[addr_s1];
		end
	end

	// stage 3 load: fields an item does not drive are zero
	always_ff @(posedge clk) begin
		if (adv) begin
			wrote_s3 <= pipe_we;
			widx_s3  <= pipe_we ? pipe_waddr : '0;
			wval_s3  <= pipe_we ? pipe_wval : '0;
			done_s3  <= is_spread && done_s2;
			rheat_s3 <= (cmd_s2 == CMD_READ && rd_ok_s2) ? heat_cur : '0;
		end
	end

	// stage 4: palette lookup into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			wrote_s4 <= wrote_s3;
			widx_s4  <= widx_s3;
			wval_s4  <= wval_s3;
			done_s4  <= done_s3;
			rheat_s4 <= rheat_s3;
			color_s4 <= palette_word(rheat_s3);
		end
	end

	assign out_valid   = v_s4;
	assign wrote       = wrote_s4;
	assign write_index = 16'(widx_s4);
	assign write_value = wval_s4;
	assign tick_done   = done_s4;
	assign read_heat   = rheat_s4;
	assign read_color  = color_s4;

	// nothing is in the front of the pipe while the sweep owns the memory
	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_active_q |-> (!v_s1 && !v_s2 && !in_ready))
		else $error("transaction in flight during memory sweep");

	// a spread never writes outside the field
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && pipe_we) |-> (32'(pipe_waddr) < CELL_COUNT))
		else $error("spread write outside heat field");

	// scan stays on rows 1..H-1 and inside the grid
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_row_q != '0) && (32'(scan_row_q) < GRID_HEIGHT)
		&& (32'(scan_col_q) < GRID_WIDTH))
		else $error("scan position out of range");

	// a result never carries both write and read fields
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (wrote_s4 || done_s4)) |-> (rheat_s4 == '0 && color_s4 == '0))
		else $error("spread result carries read fields");

	// a reseed leaving stage 2 always starts the sweep on the next cycle
	a_reseed_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_start |=> (sweep_active_q && sweep_idx_q == '0))
		else $error("reseed did not start memory sweep");

endmodule

FILE: bench/fire_cellular_automaton_core_tb.sv
// self-checking testbench for the fire cellular automaton core: heat field prediction and result compare
`timescale 1ns / 100ps

module fire_cellular_automaton_core_tb;
	import fca_pkg::*;

	localparam int GRID_W      = 320;
	localparam int GRID_H      = 168;
	localparam int CELLS       = GRID_W * GRID_H;
	localparam int LIMIT_CYCLES = 2_000_000;

	// receiver stall patterns
	localparam int RX_FREE   = 0;
	localparam int RX_HALF   = 1;
	localparam int RX_SPARSE = 2;

	// one result transaction, field for field
	typedef struct packed {
		logic        wrote;
		logic [15:0] write_index;
		heat_t       write_value;
		logic        tick_done;
		heat_t       read_heat;
		rgba_t       read_color;
	} cell_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	heat_t       cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [1:0]  rand_offset = '0;
	logic [8:0]  read_col = '0;
	logic [7:0]  read_row = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        wrote;
	logic [15:0] write_index;
	heat_t       write_value;
	logic        tick_done;
	heat_t       read_heat;
	rgba_t       read_color;

	fire_cellular_automaton_core #(
		.GRID_WIDTH (GRID_W),
		.GRID_HEIGHT(GRID_H)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.rand_offset(rand_offset),
		.read_col   (read_col),
		.read_row   (read_row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wrote      (wrote),
		.write_index(write_index),
		.write_value(write_value),
		.tick_done  (tick_done),
		.read_heat  (read_heat),
		.read_color (read_color)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted copy of the block's state
	heat_t        heat_field [CELLS];
	int           scan_col;
	int           scan_row;
	heat_t        seed_level;
	int           last_write;
	cell_result_t pending_results [$];

	int mismatch_count = 0;
	int cycle_count = 0;

	// traffic shaping knobs
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int burst_left = 1;
	int rx_mode = RX_FREE;
	int rx_left = 0;

	// flame palette as 0xRRGGBB; the block returns it as abgr with alpha 255, heat 0 transparent
	function automatic rgba_t flame_color(input int h);
		logic [23:0] rgb;
		case (h)
			0:  rgb = 24'h070707;  1:  rgb = 24'h1F0707;  2:  rgb = 24'h2F0F07;
			3:  rgb = 24'h470F07;  4:  rgb = 24'h571707;  5:  rgb = 24'h671F07;
			6:  rgb = 24'h771F07;  7:  rgb = 24'h8F2707;  8:  rgb = 24'h9F2F07;
			9:  rgb = 24'hAF3F07;  10: rgb = 24'hBF4707;  11: rgb = 24'hC74707;
			12: rgb = 24'hDF4F07;  13: rgb = 24'hDF5707;  14: rgb = 24'hDF5707;
			15: rgb = 24'hD75F07;  16: rgb = 24'hD75F07;  17: rgb = 24'hD7670F;
			18: rgb = 24'hCF6F0F;  19: rgb = 24'hCF770F;  20: rgb = 24'hCF7F0F;
			21: rgb = 24'hCF8717;  22: rgb = 24'hC78717;  23: rgb = 24'hC78F17;
			24: rgb = 24'hC7971F;  25: rgb = 24'hBF9F1F;  26: rgb = 24'hBF9F1F;
			27: rgb = 24'hBFA727;  28: rgb = 24'hBFA727;  29: rgb = 24'hBFAF2F;
			30: rgb = 24'hB7AF2F;  31: rgb = 24'hB7B72F;  32: rgb = 24'hB7B737;
			33: rgb = 24'hCFCF6F;  34: rgb = 24'hDFDF9F;  35: rgb = 24'hEFEFC7;
			default: rgb = 24'hFFFFFF;
		endcase
		return (h == 0) ? '0 : {8'hFF, rgb[7:0], rgb[15:8], rgb[23:16]};
	endfunction

	// clear the field and light the bottom row with the current seed heat
	function automatic void fill_field();
		foreach (heat_field[i])
			heat_field[i] = '0;
		for (int c = 0; c < GRID_W; c++)
			heat_field[(GRID_H - 1) * GRID_W + c] = seed_level;
	endfunction

	// next state of the field and the result that one command transaction produces
	function automatic cell_result_t predict_cell_result(input cmd_t op, input logic [1:0] off,
			input logic [8:0] col, input logic [7:0] row);
		cell_result_t res;
		int src;
		int pix;
		int tgt;
		int h;
		res = '0;
		case (op)
			CMD_RESEED: begin
				fill_field();
			end
			CMD_SPREAD: begin
				src = scan_row * GRID_W + scan_col;
				pix = heat_field[src];
				tgt = -1;
				if (pix == 0) begin
					// cold source clears the cell straight above
					if (src >= GRID_W)
						tgt = src - GRID_W;
				end else begin
					// hot source moves up and sideways on the linear index, so rows wrap
					tgt = src + 1 - int'(off) - GRID_W;
					pix = (pix - int'(off[0])) & 6'h3F;
				end
				// a target below index zero is dropped
				if (tgt >= 0 && tgt < CELLS) begin
					heat_field[tgt] = heat_t'(pix == 0 ? 0 : pix);
					if (heat_field[src] == 0)
						heat_field[tgt] = '0;
					res.wrote = 1'b1;
					res.write_index = 16'(tgt);
					res.write_value = heat_field[tgt];
					last_write = tgt;
				end
				res.tick_done = (scan_col == GRID_W - 1 && scan_row == GRID_H - 1);
				scan_row++;
				if (scan_row >= GRID_H) begin
					scan_row = 1;
					scan_col++;
					if (scan_col >= GRID_W)
						scan_col = 0;
				end
			end
			CMD_READ: begin
				// out-of-range reads return all zero
				if (int'(col) < GRID_W && int'(row) < GRID_H) begin
					h = heat_field[int'(row) * GRID_W + int'(col)];
					res.read_heat = heat_t'(h);
					res.read_color = flame_color(h > int'(HEAT_TOP) ? int'(HEAT_TOP) : h);
				end
			end
			default: ; // no operation: nothing changes, all fields zero
		endcase
		return res;
	endfunction

	// hold one command transaction until accepted, then record its prediction
	task automatic issue_command(input cmd_t op, input logic [1:0] off, input logic [8:0] col,
			input logic [7:0] row);
		int gap;
		in_valid <= 1'b1;
		cmd <= op;
		rand_offset <= off;
		read_col <= col;
		read_row <= row;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(predict_cell_result(op, off, col, row));
		// bursty sender: after a burst, drop valid for a random gap
		if (!tx_steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending, let every outstanding result come back and any field sweep finish
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (8) @(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// result check: each accepted transaction against the oldest prediction
	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s expected %h actual %h", $realtime, name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		cell_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transaction with no prediction waiting", $realtime);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				check_field("wrote", 32'(exp_res.wrote), 32'(wrote));
				check_field("write_index", 32'(exp_res.write_index), 32'(write_index));
				check_field("write_value", 32'(exp_res.write_value), 32'(write_value));
				check_field("tick_done", 32'(exp_res.tick_done), 32'(tick_done));
				check_field("read_heat", 32'(exp_res.read_heat), 32'(read_heat));
				check_field("read_color", exp_res.read_color, read_color);
			end
		end
	end

	// receiver backpressure: random stretches of free flow, coin-flip and sparse ready
	always @(posedge clk) begin
		if (rx_steady) begin
			out_ready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
				rx_left = $urandom_range(4, 60);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= 1'b1;
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// fresh field after reset: corners, out-of-range reads, no-op, each offset, reseed
	task automatic test_idle_field();
		issue_command(CMD_READ, 2'd0, 9'd0, 8'd0);
		issue_command(CMD_READ, 2'd3, 9'd319, 8'd167);
		issue_command(CMD_READ, 2'd0, 9'd0, 8'd167);
		issue_command(CMD_READ, 2'd1, 9'd319, 8'd0);
		issue_command(CMD_READ, 2'd0, 9'd320, 8'd0);
		issue_command(CMD_READ, 2'd0, 9'd0, 8'd168);
		issue_command(CMD_READ, 2'd3, 9'd511, 8'd255);
		issue_command(CMD_NOP, 2'd3, 9'd511, 8'd255);
		for (int o = 0; o < 4; o++)
			issue_command(CMD_SPREAD, 2'(o), 9'd511, 8'd255);
		issue_command(CMD_READ, 2'd0, 9'd0, 8'd0);
		issue_command(CMD_RESEED, 2'd3, 9'd511, 8'd255);
		issue_command(CMD_READ, 2'd2, 9'd5, 8'd167);
		issue_command(CMD_READ, 2'd0, 9'd319, 8'd166);
	endtask

	// mostly spreads and reads around the write front, some full-range reads and no-ops
	task automatic test_random_items(input int count);
		int pick;
		int idx;
		logic [1:0] off;
		logic [8:0] col;
		logic [7:0] row;
		for (int n = 0; n < count; n++) begin
			off = 2'($urandom_range(0, 3));
			col = 9'($urandom_range(0, 511));
			row = 8'($urandom_range(0, 255));
			// now and then hold off until the pipeline is empty
			if ($urandom_range(0, 49) == 0)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				issue_command(CMD_SPREAD, off, col, row);
			end else if (pick < 75) begin
				idx = last_write + $urandom_range(0, 2) - 1;
				if (idx < 0)
					idx = 0;
				if (idx >= CELLS)
					idx = CELLS - 1;
				issue_command(CMD_READ, off, 9'(idx % GRID_W), 8'(idx / GRID_W));
			end else if (pick < 85) begin
				issue_command(CMD_READ, off, 9'($urandom_range(0, GRID_W - 1)),
					8'(GRID_H - 1 - $urandom_range(0, 1)));
			end else if (pick < 95) begin
				issue_command(CMD_READ, off, 9'($urandom_range(0, GRID_W - 1)),
					8'($urandom_range(0, GRID_H - 1)));
			end else if (pick < 98) begin
				issue_command(CMD_READ, off, col, row);
			end else begin
				issue_command(CMD_NOP, off, col, row);
			end
		end
	endtask

	// new seed heat while idle, reseed, then a random stretch on that field
	task automatic test_seed_phase(input heat_t level, input int count);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= level;
		do
			@(posedge clk);
		while (!cfg_ready);
		seed_level = level;
		cfg_valid <= 1'b0;
		issue_command(CMD_RESEED, 2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
			8'($urandom_range(0, 255)));
		test_random_items(count);
	endtask

	// back-to-back spreads with a free-running receiver
	task automatic test_back_to_back(input int count);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		for (int n = 0; n < count; n++)
			issue_command(CMD_SPREAD, 2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
				8'($urandom_range(0, 255)));
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		// predictor starts from the reset state
		seed_level = HEAT_TOP;
		scan_col = 0;
		scan_row = 1;
		last_write = 0;
		fill_field();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_field();
		test_seed_phase(6'd63, 150);
		test_seed_phase(6'd0, 100);
		test_seed_phase(heat_t'($urandom_range(1, 35)), 150);
		test_seed_phase(HEAT_TOP, 120);
		test_back_to_back(60);
		test_random_items(100);

		drain_results();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
